### design/bipg_pkg.sv
// Shared types, codes and helpers for the BFS indirect prefetch generator.
// No dependencies; every other design file refers to this package by scope.
package bipg_pkg;

  localparam int unsigned ADDR_W           = 64;
  localparam int unsigned OFFSET_W         = 32;
  localparam int unsigned BLOCK_BYTES_LOG2 = 6;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned RES_DEPTH        = 3;

  // Input transaction modes
  localparam logic [1:0] MODE_HINT = 2'd0;
  localparam logic [1:0] MODE_OK   = 2'd1;
  localparam logic [1:0] MODE_FAIL = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Result kinds
  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_TAG   = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ABORT = 2'd3;

  // Prefetch levels
  localparam logic [1:0] LVL_NODE    = 2'd0;
  localparam logic [1:0] LVL_ROW     = 2'd1;
  localparam logic [1:0] LVL_EDGE    = 2'd2;
  localparam logic [1:0] LVL_VISITED = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HINT_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_ARRAY_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VISITED_BASE   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_NODE,
    PH_ROW_START,
    PH_ROW_END,
    PH_EDGE
  } phase_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] hint_offset;
    logic [ADDR_W-1:0]   row_array_base;
    logic [ADDR_W-1:0]   visited_array_base;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [1:0]        level;
    logic              wide_load;
    logic              last;
  } result_t;

  // Walker to result queue: results of one input transaction
  typedef struct packed {
    logic                      fire;
    logic [1:0]                count;
    result_t [RES_DEPTH-1:0]   res;
  } push_t;

  function automatic logic [ADDR_W-1:0] block_of(input logic [ADDR_W-1:0] a);
    block_of = {a[ADDR_W-1:BLOCK_BYTES_LOG2], {BLOCK_BYTES_LOG2{1'b0}}};
  endfunction

  function automatic logic [ADDR_W-1:0] align4(input logic [ADDR_W-1:0] a);
    align4 = {a[ADDR_W-1:2], 2'b00};
  endfunction

  function automatic logic [ADDR_W-1:0] align8(input logic [ADDR_W-1:0] a);
    align8 = {a[ADDR_W-1:3], 3'b000};
  endfunction

  function automatic result_t mk_res(input logic [1:0] kind,
                                     input logic [ADDR_W-1:0] address,
                                     input logic [1:0] level,
                                     input logic wide_load,
                                     input logic last);
    result_t r;
    r.kind      = kind;
    r.address   = address;
    r.level     = level;
    r.wide_load = wide_load;
    r.last      = last;
    mk_res = r;
  endfunction

endpackage

### design/bipg_in_if.sv
// Input channel interface: hint and load response transactions.
// Depends on bipg_pkg for widths.
interface bipg_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [bipg_pkg::ADDR_W-1:0]   hint_addr;
  logic [bipg_pkg::ADDR_W-1:0]   load_data;

  modport source (output valid, output mode, output hint_addr, output load_data,
                  input ready);
  modport sink (input valid, input mode, input hint_addr, input load_data,
                output ready);
endinterface

### design/bipg_out_if.sv
// Result channel interface: load requests, prefetch tags, done and abort records.
// Depends on bipg_pkg for widths.
interface bipg_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [bipg_pkg::ADDR_W-1:0]   address;
  logic [1:0]                    level;
  logic                          wide_load;
  logic                          last;

  modport source (output valid, output kind, output address, output level,
                  output wide_load, output last, input ready);
  modport sink (input valid, input kind, input address, input level,
                input wide_load, input last, output ready);
endinterface

### design/bipg_cfg_if.sv
// Configuration write channel interface: register index and write data.
// Depends on bipg_pkg for widths.
interface bipg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bipg_pkg::CFG_IDX_W-1:0] index;
  logic [bipg_pkg::ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/bipg_cfg_regs.sv
// Configuration register file: hint offset and the two array bases.
// Depends on bipg_pkg and bipg_cfg_if.
module bipg_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  bipg_cfg_if.sink         cfg_ch,
  output bipg_pkg::cfg_t   cfg
);

  bipg_pkg::cfg_t cfg_r;
  bipg_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bipg_pkg::CFG_HINT_OFFSET:
          cfg_nxt.hint_offset = cfg_ch.data[bipg_pkg::OFFSET_W-1:0];
        bipg_pkg::CFG_ROW_ARRAY_BASE: cfg_nxt.row_array_base = cfg_ch.data;
        bipg_pkg::CFG_VISITED_BASE:   cfg_nxt.visited_array_base = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### design/bipg_walker.sv
// Walk engine: input register, CSR walk state and per-transaction result set.
// Depends on bipg_pkg and bipg_in_if.
module bipg_walker (
  input  logic             clk,
  input  logic             rst_n,
  bipg_in_if.sink          in_ch,
  input  bipg_pkg::cfg_t   cfg,
  input  logic             q_free,
  output bipg_pkg::push_t  push
);

  localparam int unsigned AW = bipg_pkg::ADDR_W;

  logic            in_vld_r;
  logic [1:0]      mode_r;
  logic [AW-1:0]   hint_r;
  logic [AW-1:0]   data_r;

  bipg_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0]   work_r, work_nxt;
  logic [AW-1:0]   row_r, row_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   end_r, end_nxt;

  logic            step_fire;
  logic [AW-1:0]   hint_work;
  logic [AW-1:0]   row_new;
  logic [AW-1:0]   row_second;
  logic [AW-1:0]   cur_step;
  logic [AW-1:0]   vis_addr;
  logic            range_ok;
  logic            step_ok;
  logic            new_block;

  assign step_fire   = in_vld_r & q_free;
  assign in_ch.ready = !in_vld_r || step_fire;

  // Hold one transaction until the result queue can take its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      hint_r <= in_ch.hint_addr;
      data_r <= in_ch.load_data;
    end
  end

  assign hint_work  = hint_r - {30'b0, cfg.hint_offset, 2'b00};
  assign row_new    = cfg.row_array_base + {29'b0, data_r[31:0], 3'b000};
  assign row_second = row_r + 64'd8;
  assign cur_step   = cur_r + 64'd4;
  assign vis_addr   = cfg.visited_array_base + {30'b0, data_r[31:0], 2'b00};
  assign range_ok   = cur_r < data_r;
  assign step_ok    = cur_step < end_r;
  assign new_block  = bipg_pkg::block_of(cur_step) != bipg_pkg::block_of(cur_r);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    work_nxt  = work_r;
    row_nxt   = row_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    if (step_fire) begin
      unique case (mode_r)
        bipg_pkg::MODE_HINT: begin
          if (phase_r == bipg_pkg::PH_IDLE) begin
            work_nxt  = hint_work;
            phase_nxt = bipg_pkg::PH_NODE;
          end
        end
        bipg_pkg::MODE_FAIL: phase_nxt = bipg_pkg::PH_IDLE;
        bipg_pkg::MODE_OK: begin
          unique case (phase_r)
            bipg_pkg::PH_IDLE: ;
            bipg_pkg::PH_NODE: begin
              row_nxt   = row_new;
              phase_nxt = bipg_pkg::PH_ROW_START;
            end
            bipg_pkg::PH_ROW_START: begin
              cur_nxt   = data_r;
              phase_nxt = bipg_pkg::PH_ROW_END;
            end
            bipg_pkg::PH_ROW_END: begin
              end_nxt   = data_r;
              phase_nxt = range_ok ? bipg_pkg::PH_EDGE : bipg_pkg::PH_IDLE;
            end
            bipg_pkg::PH_EDGE: begin
              cur_nxt   = cur_step;
              phase_nxt = step_ok ? bipg_pkg::PH_EDGE : bipg_pkg::PH_IDLE;
            end
            default: phase_nxt = bipg_pkg::PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Results of the transaction in the input register
  always_comb begin
    push.fire  = step_fire;
    push.count = 2'd0;
    push.res   = '0;
    unique case (mode_r)
      bipg_pkg::MODE_HINT: begin
        if (phase_r == bipg_pkg::PH_IDLE) begin
          push.count  = 2'd1;
          push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align4(hint_work),
                                         bipg_pkg::LVL_NODE, 1'b0, 1'b1);
        end
      end
      bipg_pkg::MODE_FAIL: begin
        if (phase_r != bipg_pkg::PH_IDLE) begin
          push.count  = 2'd1;
          push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_ABORT, work_r,
                                         bipg_pkg::LVL_NODE, 1'b0, 1'b1);
        end
      end
      bipg_pkg::MODE_OK: begin
        unique case (phase_r)
          bipg_pkg::PH_IDLE: ;
          bipg_pkg::PH_NODE: begin
            push.count  = 2'd2;
            push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_TAG, bipg_pkg::block_of(work_r),
                                           bipg_pkg::LVL_NODE, 1'b0, 1'b0);
            push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align8(row_new),
                                           bipg_pkg::LVL_ROW, 1'b1, 1'b1);
          end
          bipg_pkg::PH_ROW_START: begin
            push.count  = 2'd2;
            push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_TAG, bipg_pkg::block_of(row_r),
                                           bipg_pkg::LVL_ROW, 1'b0, 1'b0);
            push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align8(row_second),
                                           bipg_pkg::LVL_ROW, 1'b1, 1'b1);
          end
          bipg_pkg::PH_ROW_END: begin
            push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_TAG,
                                           bipg_pkg::block_of(row_second),
                                           bipg_pkg::LVL_ROW, 1'b0, 1'b0);
            if (range_ok) begin
              push.count  = 2'd3;
              push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_TAG, bipg_pkg::block_of(cur_r),
                                             bipg_pkg::LVL_EDGE, 1'b0, 1'b0);
              push.res[2] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align4(cur_r),
                                             bipg_pkg::LVL_EDGE, 1'b0, 1'b1);
            end else begin
              push.count  = 2'd2;
              push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_DONE, work_r,
                                             bipg_pkg::LVL_NODE, 1'b0, 1'b1);
            end
          end
          bipg_pkg::PH_EDGE: begin
            push.res[0] = bipg_pkg::mk_res(bipg_pkg::K_TAG, bipg_pkg::block_of(vis_addr),
                                           bipg_pkg::LVL_VISITED, 1'b0, 1'b0);
            if (!step_ok) begin
              push.count  = 2'd2;
              push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_DONE, work_r,
                                             bipg_pkg::LVL_NODE, 1'b0, 1'b1);
            end else if (new_block) begin
              push.count  = 2'd3;
              push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_TAG,
                                             bipg_pkg::block_of(cur_step),
                                             bipg_pkg::LVL_EDGE, 1'b0, 1'b0);
              push.res[2] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align4(cur_step),
                                             bipg_pkg::LVL_EDGE, 1'b0, 1'b1);
            end else begin
              push.count  = 2'd2;
              push.res[1] = bipg_pkg::mk_res(bipg_pkg::K_LOAD, bipg_pkg::align4(cur_step),
                                             bipg_pkg::LVL_EDGE, 1'b0, 1'b1);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bipg_pkg::PH_IDLE;
      work_r  <= '0;
      row_r   <= '0;
      cur_r   <= '0;
      end_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      work_r  <= work_nxt;
      row_r   <= row_nxt;
      cur_r   <= cur_nxt;
      end_r   <= end_nxt;
    end
  end

  // The edge walk only runs while the cursor is below the end pointer
  a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bipg_pkg::PH_EDGE |-> cur_r < end_r)
    else $error("edge walk active with cursor at or past end");

  a_hint_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && mode_r == bipg_pkg::MODE_HINT && phase_r == bipg_pkg::PH_IDLE)
    |=> phase_r == bipg_pkg::PH_NODE)
    else $error("accepted hint did not start a node fetch");

endmodule

### design/bipg_result_queue.sv
// Three-entry queue: loads a transaction's results, drains one per cycle while ready.
// Depends on bipg_pkg and bipg_out_if.
module bipg_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bipg_pkg::push_t  push,
  output logic             q_free,
  bipg_out_if.source       out_ch
);

  bipg_pkg::result_t [bipg_pkg::RES_DEPTH-1:0] ent_r, ent_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop    = (cnt_r != 2'd0) && out_ch.ready;
  assign q_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  assign out_ch.valid     = cnt_r != 2'd0;
  assign out_ch.kind      = ent_r[0].kind;
  assign out_ch.address   = ent_r[0].address;
  assign out_ch.level     = ent_r[0].level;
  assign out_ch.wide_load = ent_r[0].wide_load;
  assign out_ch.last      = ent_r[0].last;

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (push.fire) begin
      ent_nxt = push.res;
      cnt_nxt = push.count;
    end else if (pop) begin
      // Advance toward the head
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    push.fire |-> (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop))
    else $error("results loaded over undelivered results");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd1 |-> ent_r[0].last)
    else $error("final queued result not marked last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(ent_r[0]))
    else $error("head result changed while the consumer stalled");

endmodule

### design/bfs_indirect_prefetch_generator_core.sv
// BFS indirect prefetch generator, top level. An accepted transaction is registered in
// the walker's input register; its results are loaded into the result queue, whose head
// drives the output. Throughput: one input transaction per cycle while each yields one
// result and the consumer is ready; extra results hold the input at the output port.
// Reset (rst_n low, synchronous): walk idle, walk state and config cleared, queue empty.
// Depends on bipg_pkg, the three channel interfaces, cfg regs, walker and queue.
module bfs_indirect_prefetch_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  bipg_in_if.sink     in_ch,
  bipg_out_if.source  out_ch,
  bipg_cfg_if.sink    cfg_ch
);

  // Configuration: hint offset, row pointer array base, visited array base.
  // Writes are issued by the user only while the block is idle; the block does not check.
  bipg_pkg::cfg_t  cfg;

  // Walker hands each transaction's results (up to three) to the queue in one
  // shot; the queue reports free when it is empty or handing out its last entry,
  // so a new transaction moves in the same cycle the previous one finishes.
  bipg_pkg::push_t push;
  logic            q_free;

  bipg_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Input register plus the CSR chase: node id, row pointer pair, edge indices,
  // visited entries. All arithmetic is one add or shift and one compare deep.
  bipg_walker u_walker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_free (q_free),
    .push   (push)
  );

  // Result register stage: holds finished results while the consumer stalls,
  // decoupling the output handshake from the walk.
  bipg_result_queue u_result_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_free (q_free),
    .out_ch (out_ch)
  );

endmodule

### verif/bipg_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the BFS indirect prefetch generator: watches the three channels,
// predicts every result from accepted transactions and compares in order.
// Depends on bipg_pkg and the three channel interfaces.
module bipg_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  bipg_in_if          in_mon,
  bipg_out_if         out_mon,
  bipg_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked
);

  localparam logic [bipg_pkg::ADDR_W-1:0] BLOCK_MASK =
    ~((64'd1 << bipg_pkg::BLOCK_BYTES_LOG2) - 64'd1);

  logic [bipg_pkg::OFFSET_W-1:0] prefetch_distance;
  logic [bipg_pkg::ADDR_W-1:0]   row_base;
  logic [bipg_pkg::ADDR_W-1:0]   visited_base;

  bipg_pkg::phase_t            walk_phase;
  logic [bipg_pkg::ADDR_W-1:0] work_addr;
  logic [bipg_pkg::ADDR_W-1:0] row_entry;
  logic [bipg_pkg::ADDR_W-1:0] edge_ptr;
  logic [bipg_pkg::ADDR_W-1:0] edge_limit;

  bipg_pkg::result_t burst[$];
  bipg_pkg::result_t awaited_records[$];
  int unsigned       fail_count;
  int unsigned       seen_count;

  function automatic void note(input logic [1:0] kind,
                               input logic [bipg_pkg::ADDR_W-1:0] addr,
                               input logic [1:0] level, input logic wide);
    bipg_pkg::result_t r;
    r.kind      = kind;
    r.address   = addr;
    r.level     = level;
    r.wide_load = wide;
    r.last      = 1'b0;
    burst = {burst, r};
  endfunction

  // Advance the walk by one input transaction and queue the records it causes.
  function automatic void chase_chain(input logic [1:0] mode,
                                      input logic [bipg_pkg::ADDR_W-1:0] hint,
                                      input logic [bipg_pkg::ADDR_W-1:0] data);
    logic [bipg_pkg::ADDR_W-1:0] prev_blk;
    bipg_pkg::result_t           r;
    burst.delete();
    if (mode == bipg_pkg::MODE_HINT) begin
      if (walk_phase == bipg_pkg::PH_IDLE) begin
        work_addr = hint - (64'(prefetch_distance) << 2);
        note(bipg_pkg::K_LOAD, work_addr & ~64'd3, bipg_pkg::LVL_NODE, 1'b0);
        walk_phase = bipg_pkg::PH_NODE;
      end
    end else if (mode == bipg_pkg::MODE_FAIL && walk_phase != bipg_pkg::PH_IDLE) begin
      note(bipg_pkg::K_ABORT, work_addr, bipg_pkg::LVL_NODE, 1'b0);
      walk_phase = bipg_pkg::PH_IDLE;
    end else if (mode == bipg_pkg::MODE_OK && walk_phase != bipg_pkg::PH_IDLE) begin
      case (walk_phase)
        bipg_pkg::PH_NODE: begin
          note(bipg_pkg::K_TAG, work_addr & BLOCK_MASK, bipg_pkg::LVL_NODE, 1'b0);
          row_entry = row_base + (64'(data[31:0]) << 3);
          note(bipg_pkg::K_LOAD, row_entry & ~64'd7, bipg_pkg::LVL_ROW, 1'b1);
          walk_phase = bipg_pkg::PH_ROW_START;
        end
        bipg_pkg::PH_ROW_START: begin
          edge_ptr = data;
          note(bipg_pkg::K_TAG, row_entry & BLOCK_MASK, bipg_pkg::LVL_ROW, 1'b0);
          note(bipg_pkg::K_LOAD, (row_entry + 64'd8) & ~64'd7, bipg_pkg::LVL_ROW, 1'b1);
          walk_phase = bipg_pkg::PH_ROW_END;
        end
        bipg_pkg::PH_ROW_END: begin
          edge_limit = data;
          note(bipg_pkg::K_TAG, (row_entry + 64'd8) & BLOCK_MASK, bipg_pkg::LVL_ROW, 1'b0);
          if (edge_ptr < edge_limit) begin
            note(bipg_pkg::K_TAG, edge_ptr & BLOCK_MASK, bipg_pkg::LVL_EDGE, 1'b0);
            note(bipg_pkg::K_LOAD, edge_ptr & ~64'd3, bipg_pkg::LVL_EDGE, 1'b0);
            walk_phase = bipg_pkg::PH_EDGE;
          end else begin
            note(bipg_pkg::K_DONE, work_addr, bipg_pkg::LVL_NODE, 1'b0);
            walk_phase = bipg_pkg::PH_IDLE;
          end
        end
        bipg_pkg::PH_EDGE: begin
          prev_blk = edge_ptr & BLOCK_MASK;
          note(bipg_pkg::K_TAG, (visited_base + (64'(data[31:0]) << 2)) & BLOCK_MASK,
               bipg_pkg::LVL_VISITED, 1'b0);
          edge_ptr = edge_ptr + 64'd4;
          if (edge_ptr < edge_limit) begin
            if ((edge_ptr & BLOCK_MASK) != prev_blk)
              note(bipg_pkg::K_TAG, edge_ptr & BLOCK_MASK, bipg_pkg::LVL_EDGE, 1'b0);
            note(bipg_pkg::K_LOAD, edge_ptr & ~64'd3, bipg_pkg::LVL_EDGE, 1'b0);
          end else begin
            note(bipg_pkg::K_DONE, work_addr, bipg_pkg::LVL_NODE, 1'b0);
            walk_phase = bipg_pkg::PH_IDLE;
          end
        end
        default: walk_phase = bipg_pkg::PH_IDLE;
      endcase
    end
    foreach (burst[i]) begin
      r      = burst[i];
      r.last = (i == burst.size() - 1);
      awaited_records = {awaited_records, r};
    end
  endfunction

  always @(posedge clk) begin
    bipg_pkg::result_t want;
    if (!rst_n) begin
      prefetch_distance = '0;
      row_base          = '0;
      visited_base      = '0;
      walk_phase        = bipg_pkg::PH_IDLE;
      work_addr         = '0;
      row_entry         = '0;
      edge_ptr          = '0;
      edge_limit        = '0;
      awaited_records.delete();
    end else begin
      // Compare first, so a record pushed at this edge never pairs with this edge's output.
      if (out_mon.valid && out_mon.ready) begin
        seen_count++;
        if (awaited_records.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none, actual kind=%0d address=%h level=%0d",
                   $time, out_mon.kind, out_mon.address, out_mon.level);
        end else begin
          want = awaited_records.pop_front();
          if (out_mon.kind !== want.kind) begin
            fail_count++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_mon.kind);
          end
          if (out_mon.address !== want.address) begin
            fail_count++;
            $display("%0t: address expected %h actual %h", $time, want.address,
                     out_mon.address);
          end
          if (out_mon.level !== want.level) begin
            fail_count++;
            $display("%0t: level expected %0d actual %0d", $time, want.level, out_mon.level);
          end
          if (out_mon.wide_load !== want.wide_load) begin
            fail_count++;
            $display("%0t: wide_load expected %0d actual %0d", $time, want.wide_load,
                     out_mon.wide_load);
          end
          if (out_mon.last !== want.last) begin
            fail_count++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_mon.last);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          bipg_pkg::CFG_HINT_OFFSET:
            prefetch_distance = cfg_mon.data[bipg_pkg::OFFSET_W-1:0];
          bipg_pkg::CFG_ROW_ARRAY_BASE: row_base     = cfg_mon.data;
          bipg_pkg::CFG_VISITED_BASE:   visited_base = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        chase_chain(in_mon.mode, in_mon.hint_addr, in_mon.load_data);
    end
    mismatches <= fail_count;
    pending    <= awaited_records.size();
    checked    <= seen_count;
  end

endmodule

### verif/bfs_indirect_prefetch_generator_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the BFS indirect prefetch generator core: drives hints, load
// responses and register writes; bipg_result_checker does all prediction and checking.
module bfs_indirect_prefetch_generator_core_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Drain time after the last awaited result; leave headroom for ignored transactions.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_EDGES    = 32;
  localparam int unsigned PHASE_ITEMS  = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned accepted_items = 0;
  int unsigned ignored_items = 0;
  int unsigned walks_done = 0;
  int unsigned walks_aborted = 0;
  int unsigned settings_used = 0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  bipg_in_if  in_ch ();
  bipg_out_if out_ch ();
  bipg_cfg_if cfg_ch ();

  bfs_indirect_prefetch_generator_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bipg_result_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #2 clk = ~clk;

  // Hold the run to a hard ceiling; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited", $time,
               cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side about a quarter of the time, except in the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Count how many edge words the walk will fetch for a row pointer pair.
  function automatic int unsigned edges_in(input logic [63:0] from, input logic [63:0] upto);
    logic [63:0] cur;
    int unsigned n;
    cur = from;
    n   = 0;
    while (cur < upto && n <= MAX_EDGES) begin
      cur = cur + 64'd4;
      n++;
    end
    return n;
  endfunction

  // Present one input transaction, with a random gap before it, and hold until accepted.
  // Leave valid high afterwards; a gap in the next call or the drain lowers it.
  task automatic push_item(input logic [1:0] mode, input logic [63:0] hint,
                           input logic [63:0] data, input bit ignored);
    if (!calm && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 26) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.hint_addr <= hint;
    in_ch.load_data <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (ignored) ignored_items++;
    else accepted_items++;
  endtask

  // Transactions the block must drop while a walk is in flight.
  task automatic push_busy_noise();
    if ($urandom_range(1)) push_item(bipg_pkg::MODE_NONE, rand64(), rand64(), 1'b1);
    else push_item(bipg_pkg::MODE_HINT, rand64(), rand64(), 1'b1);
  endtask

  // Transactions the block must drop while idle.
  task automatic push_idle_noise();
    case ($urandom_range(2))
      0: push_item(bipg_pkg::MODE_OK, rand64(), rand64(), 1'b1);
      1: push_item(bipg_pkg::MODE_FAIL, rand64(), rand64(), 1'b1);
      default: push_item(bipg_pkg::MODE_NONE, rand64(), rand64(), 1'b1);
    endcase
  endtask

  // Drop input valid and wait until every predicted record is out, plus drain time.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bipg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Write all three registers back to back; random upper bits on the offset check masking.
  task automatic write_settings(input logic [31:0] offset, input logic [63:0] row_base,
                                input logic [63:0] visited_base);
    write_reg(bipg_pkg::CFG_HINT_OFFSET, {$urandom, offset});
    write_reg(bipg_pkg::CFG_ROW_ARRAY_BASE, row_base);
    write_reg(bipg_pkg::CFG_VISITED_BASE, visited_base);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // One work item: hint, node id, both row pointers, then one response per edge.
  // fail_at names the response step that fails instead (0 for none).
  task automatic run_walk(input logic [63:0] hint, input logic [31:0] node,
                          input logic [63:0] first_edge, input logic [63:0] edge_stop,
                          input int unsigned fail_at, input bit noisy);
    int unsigned n;
    int unsigned step;
    logic [63:0] word;
    n = edges_in(first_edge, edge_stop);
    push_item(bipg_pkg::MODE_HINT, hint, rand64(), 1'b0);
    for (step = 1; step <= 3 + n; step++) begin
      if (noisy && $urandom_range(99) < 12) push_busy_noise();
      if (step == fail_at) begin
        push_item(bipg_pkg::MODE_FAIL, rand64(), rand64(), 1'b0);
        walks_aborted++;
        return;
      end
      case (step)
        1: word = {$urandom, node};
        2: word = first_edge;
        3: word = edge_stop;
        default: begin
          case ($urandom_range(7))
            0: word = 64'd0;
            1: word = '1;
            default: word = rand64();
          endcase
        end
      endcase
      push_item(bipg_pkg::MODE_OK, rand64(), word, 1'b0);
    end
    walks_done++;
  endtask

  task automatic random_walk();
    logic [63:0] hint;
    logic [63:0] first_edge;
    logic [63:0] edge_stop;
    int unsigned count;
    int unsigned n;
    int unsigned fail_at;
    case ($urandom_range(3))
      0: hint = 64'($urandom_range(4095));
      1: hint = '1 - 64'($urandom_range(4095));
      default: hint = rand64();
    endcase
    first_edge = ($urandom_range(3) == 0) ? rand64() : 64'($urandom);
    if ($urandom_range(9) == 0) begin
      // Reversed or empty range: the walk finishes right after the row tags.
      edge_stop = first_edge - 64'($urandom_range(64));
    end else begin
      count     = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(1, 6);
      edge_stop = first_edge + 64'(4 * count) - 64'($urandom_range(3));
    end
    // Keep the edge count bounded where the cursor would wrap.
    if (edges_in(first_edge, edge_stop) > MAX_EDGES) edge_stop = first_edge;
    n       = edges_in(first_edge, edge_stop);
    fail_at = ($urandom_range(99) < 12) ? $urandom_range(1, 3 + n) : 0;
    run_walk(hint, $urandom, first_edge, edge_stop, fail_at, $urandom_range(99) < 30);
  endtask

  initial begin
    int unsigned ph;
    int unsigned target;

    in_ch.valid     = 1'b0;
    in_ch.mode      = bipg_pkg::MODE_NONE;
    in_ch.hint_addr = '0;
    in_ch.load_data = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = bipg_pkg::CFG_HINT_OFFSET;
    cfg_ch.data     = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero registers, then field extremes and every exit path.
    write_settings(32'd0, 64'd0, 64'd0);
    push_idle_noise();
    push_item(bipg_pkg::MODE_OK, rand64(), rand64(), 1'b1);
    push_item(bipg_pkg::MODE_FAIL, rand64(), rand64(), 1'b1);
    run_walk(64'd0, 32'd0, 64'd0, 64'd4, 0, 1'b0);
    run_walk('1, 32'hFFFF_FFFF, '1, 64'd0, 0, 1'b0);
    // Edges straddle a block boundary, so another edge tag appears mid-walk.
    run_walk(64'h1000, 32'd5, 64'h38, 64'h48, 0, 1'b0);
    // Hint and idle mode while busy, then a failed node load.
    push_item(bipg_pkg::MODE_HINT, 64'h2000, rand64(), 1'b0);
    push_item(bipg_pkg::MODE_HINT, rand64(), rand64(), 1'b1);
    push_item(bipg_pkg::MODE_NONE, rand64(), rand64(), 1'b1);
    push_item(bipg_pkg::MODE_FAIL, rand64(), rand64(), 1'b0);
    walks_aborted++;
    run_walk(64'h3004, 32'd7, 64'h100, 64'h80, 3, 1'b0);
    run_walk(64'h4008, 32'd9, 64'h200, 64'h20c, 4, 1'b0);
    settle();

    // Random: several register settings, the top extremes first, one phase with no stalls.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_settings('1, '1, '1);
        2: write_settings($urandom_range(16), rand64(), rand64());
        default: write_settings($urandom, rand64(), rand64());
      endcase
      calm   <= (ph == 3);
      target = accepted_items + PHASE_ITEMS;
      while (accepted_items < target) begin
        if ($urandom_range(99) < 8) push_idle_noise();
        else random_walk();
      end
      settle();
    end
    calm <= 1'b0;

    $display("Covered %0d accepted transactions (%0d ignored): %0d walks finished, %0d aborted",
             accepted_items, ignored_items, walks_done, walks_aborted);
    $display("across %0d register settings; %0d result transactions checked",
             settings_used, checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
